FILE: rtl/arpc_pkg.sv
`timescale 1ns / 1ps
// Package for the ARP address cache: table geometry, command codes and
// the command/status structs between controller and datapath. No dependencies.
package arpc_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 5;
  localparam int ADDR_W   = 32;
  localparam int MAC_W    = 48;
  localparam int CMD_W    = 2;

  localparam int IN_DATA_W  = 80;   // ipv4_addr, mac_addr
  localparam int OUT_DATA_W = 56;   // mac_out, entries, zero pad

  typedef logic [CMD_W-1:0] arpc_op_t;
  localparam arpc_op_t CMD_UPSERT = 2'd0;
  localparam arpc_op_t CMD_LOOKUP = 2'd1;
  localparam arpc_op_t CMD_CLEAR  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } arpc_state_t;

  typedef struct packed {
    logic capture;   // latch the incoming word
    logic execute;   // search, update table, load result register
  } arpc_cmd_t;

  typedef struct packed {
    logic out_busy;  // result register full and not being drained
  } arpc_sts_t;

endpackage

FILE: rtl/arpc_ctrl.sv
`timescale 1ns / 1ps
// Controller of the ARP address cache: two-state sequencer issuing
// capture and execute commands. Depends on arpc_pkg.
module arpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output arpc_pkg::arpc_cmd_t cmd,
  input  arpc_pkg::arpc_sts_t sts
);
  import arpc_pkg::*;

  arpc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_SEARCH: begin
        cmd.execute = !sts.out_busy;
      end
      default: ;
    endcase
  end

  a_accept_to_search: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_SEARCH)
    else $error("accepted word did not start a search");

  a_execute_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> state_r == ST_IDLE)
    else $error("controller did not return to idle after execute");

endmodule

FILE: rtl/arpc_dpath.sv
`timescale 1ns / 1ps
// Datapath of the ARP address cache: slot table, parallel address compare,
// free-slot encoder, entry counter and result register. Depends on arpc_pkg.
module arpc_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [arpc_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [arpc_pkg::CMD_W-1:0]         in_tuser,
  input  arpc_pkg::arpc_cmd_t                cmd,
  output arpc_pkg::arpc_sts_t                sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [arpc_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tuser
);
  import arpc_pkg::*;

  // captured word
  arpc_op_t          op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [MAC_W-1:0]  mac_r;

  // table
  logic [CAPACITY-1:0] slot_valid_r, slot_valid_nxt;
  logic [ADDR_W-1:0]   slot_ipv4_r [CAPACITY];
  logic [MAC_W-1:0]    slot_mac_r  [CAPACITY];
  logic [CNT_W-1:0]    count_r, count_nxt;

  // result register
  logic              out_valid_r;
  logic              out_ok_r, ok_nxt;
  logic [MAC_W-1:0]  out_mac_r, mac_nxt;
  logic [CNT_W-1:0]  out_cnt_r;

  logic [CAPACITY-1:0] match;
  logic                hit, has_free;
  logic [IDX_W-1:0]    hit_idx, free_idx, wr_idx;
  logic                wr_mac, wr_new;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_tuser;
      addr_r <= in_tdata[ADDR_W-1:0];
      mac_r  <= in_tdata[ADDR_W+MAC_W-1:ADDR_W];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = slot_valid_r[i] && (slot_ipv4_r[i] == addr_r);
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i])         hit_idx  = IDX_W'(i);
      if (!slot_valid_r[i]) free_idx = IDX_W'(i);
    end
    hit      = |match;
    has_free = !(&slot_valid_r);
  end

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    count_nxt      = count_r;
    ok_nxt         = 1'b0;
    mac_nxt        = '0;
    wr_mac         = 1'b0;
    wr_new         = 1'b0;
    wr_idx         = hit ? hit_idx : free_idx;
    unique case (op_r)
      CMD_UPSERT: begin
        if (hit) begin
          wr_mac = 1'b1;
          ok_nxt = 1'b1;
        end else if (has_free) begin
          wr_mac                 = 1'b1;
          wr_new                 = 1'b1;
          slot_valid_nxt[free_idx] = 1'b1;
          count_nxt              = count_r + CNT_W'(1);
          ok_nxt                 = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (hit) begin
          mac_nxt = slot_mac_r[hit_idx];
          ok_nxt  = 1'b1;
        end
      end
      CMD_CLEAR: begin
        slot_valid_nxt = '0;
        count_nxt      = '0;
        ok_nxt         = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      count_r      <= '0;
    end else if (cmd.execute) begin
      slot_valid_r <= slot_valid_nxt;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && wr_mac) begin
      slot_mac_r[wr_idx] <= mac_r;
    end
    if (cmd.execute && wr_new) begin
      slot_ipv4_r[wr_idx] <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.execute) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_ok_r  <= ok_nxt;
      out_mac_r <= mac_nxt;
      out_cnt_r <= count_nxt;
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tuser    = out_ok_r;
  assign out_tdata    = {{(OUT_DATA_W - MAC_W - CNT_W){1'b0}}, out_cnt_r, out_mac_r};

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(slot_valid_r)))
    else $error("entry count out of step with valid slots");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("address stored in more than one valid slot");

  a_execute_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid_r)
    else $error("execute did not load the result register");

endmodule

FILE: rtl/arp_address_cache.sv
`timescale 1ns / 1ps
// ARP address cache top level: 16-slot IPv4 to MAC table. The edge that accepts
// the input word captures it; the search state then runs the parallel compare,
// table update and result register load. No new word is accepted until then.
// A full result register stalls the update cycle until out_tready drains it.
// Reset: synchronous active-low rst_n clears all valid bits and the count.
module arp_address_cache (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [arpc_pkg::IN_DATA_W-1:0]  in_tdata,   // ipv4_addr[31:0], mac_addr[79:32]
  input  logic [arpc_pkg::CMD_W-1:0]      in_tuser,   // command[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [arpc_pkg::OUT_DATA_W-1:0] out_tdata,  // mac_out[47:0], entries[52:48]
  output logic                            out_tuser   // ok[0]
);
  import arpc_pkg::*;

  arpc_cmd_t cmd;
  arpc_sts_t sts;

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  arpc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
